// ----- design/pip_pkg.sv -----
package pip_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE           = 3'd0,
        REG_GAIN_PROP      = 3'd1,
        REG_GAIN_INTEG     = 3'd2,
        REG_GAIN_DERIV     = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_OUTPUT_LIMIT   = 3'd5,
        REG_MAX_ERROR      = 3'd6,
        REG_DEAD_BAND      = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        MODE_POSITION    = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] gain_prop;
        logic [15:0] gain_integ;
        logic [15:0] gain_deriv;
        logic [30:0] integral_limit;
        logic [30:0] output_limit;
        logic [15:0] max_error;
        logic [15:0] dead_band;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        if (x > 35'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (x < -35'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_mag(input logic signed [31:0] x,
                                                     input logic [30:0]        lim);
        logic signed [32:0] l;
        logic signed [32:0] nl;
        logic signed [32:0] xs;
        l  = $signed({2'b00, lim});
        nl = -l;
        xs = 33'(x);
        if (xs > l) begin
            return l[31:0];
        end else if (xs < nl) begin
            return nl[31:0];
        end
        return x;
    endfunction

endpackage

// ----- design/pip_if.sv -----
interface pip_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] measured;
    logic [15:0] target;

    modport source (output valid, output measured, output target, input ready);
    modport sink   (input valid, input measured, input target, output ready);
endinterface

interface pip_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] drive;
    logic        gated;

    modport source (output valid, output drive, output gated, input ready);
    modport sink   (input valid, input drive, input gated, output ready);
endinterface

interface pip_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/pip_cfg.sv -----
module pip_cfg
    import pip_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    pip_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                REG_MODE:           n_cfg.mode           = t_mode'(i_cfg.data[0]);
                REG_GAIN_PROP:      n_cfg.gain_prop      = i_cfg.data[15:0];
                REG_GAIN_INTEG:     n_cfg.gain_integ     = i_cfg.data[15:0];
                REG_GAIN_DERIV:     n_cfg.gain_deriv     = i_cfg.data[15:0];
                REG_INTEGRAL_LIMIT: n_cfg.integral_limit = i_cfg.data[30:0];
                REG_OUTPUT_LIMIT:   n_cfg.output_limit   = i_cfg.data[30:0];
                REG_MAX_ERROR:      n_cfg.max_error      = i_cfg.data[15:0];
                REG_DEAD_BAND:      n_cfg.dead_band      = i_cfg.data[15:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- design/pip_core.sv -----
module pip_core
    import pip_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_adv,
    input  logic        [15:0] i_measured,
    input  logic        [15:0] i_target,
    output logic signed [31:0] o_drive,
    output logic               o_gated
);

    logic signed [16:0] r_err_prev;
    logic signed [16:0] r_err_prev2;
    logic signed [31:0] r_integral_sum;
    logic signed [31:0] r_last_drive;

    logic signed [16:0] w_err;
    logic        [16:0] w_mag;
    logic signed [17:0] w_d1;
    logic signed [18:0] w_d2;
    logic signed [17:0] w_prop_op;
    logic signed [18:0] w_deriv_op;
    logic signed [33:0] w_prop_prod;
    logic signed [32:0] w_integ_prod;
    logic signed [34:0] w_deriv_prod;
    logic signed [33:0] w_p;
    logic signed [32:0] w_i;
    logic signed [34:0] w_d;
    logic signed [31:0] w_i_pos;
    logic signed [31:0] w_i_inc;
    logic signed [31:0] w_i_term;
    logic signed [31:0] w_sum;
    logic signed [31:0] w_res_inc;
    logic signed [31:0] w_res;
    logic               w_gated;
    logic               w_incr;

    assign w_incr = (i_cfg.mode == MODE_INCREMENTAL);

    assign w_err = $signed({i_target[15], i_target}) - $signed({i_measured[15], i_measured});
    assign w_mag = w_err[16] ? 17'(-w_err) : w_err;

    assign w_gated = ((i_cfg.max_error != '0) && (w_mag > {1'b0, i_cfg.max_error})) ||
                     ((i_cfg.dead_band != '0) && (w_mag < {1'b0, i_cfg.dead_band}));

    // error differences for the derivative and incremental terms
    assign w_d1 = 18'(w_err) - 18'(r_err_prev);
    assign w_d2 = 19'(w_err) - (19'(r_err_prev) <<< 1) + 19'(r_err_prev2);

    assign w_prop_op  = w_incr ? w_d1 : 18'(w_err);
    assign w_deriv_op = w_incr ? w_d2 : 19'(w_d1);

    assign w_prop_prod  = $signed(i_cfg.gain_prop)  * w_prop_op;
    assign w_integ_prod = $signed(i_cfg.gain_integ) * w_err;
    assign w_deriv_prod = $signed(i_cfg.gain_deriv) * w_deriv_op;

    assign w_p = w_prop_prod  >>> GAIN_FRAC_BITS;
    assign w_i = w_integ_prod >>> GAIN_FRAC_BITS;
    assign w_d = w_deriv_prod >>> GAIN_FRAC_BITS;

    assign w_i_pos  = clamp_mag(sat32(35'(r_integral_sum) + 35'(w_i)), i_cfg.integral_limit);
    assign w_i_inc  = clamp_mag(sat32(35'(w_i)), i_cfg.integral_limit);
    assign w_i_term = w_incr ? w_i_inc : w_i_pos;

    assign w_sum     = sat32(35'(w_p) + 35'(w_i_term) + w_d);
    assign w_res_inc = sat32(35'(r_last_drive) + 35'(w_sum));
    assign w_res     = clamp_mag(w_incr ? w_res_inc : w_sum, i_cfg.output_limit);

    assign o_drive = w_gated ? 32'sd0 : w_res;
    assign o_gated = w_gated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_prev     <= '0;
            r_err_prev2    <= '0;
            r_integral_sum <= '0;
            r_last_drive   <= '0;
        end else if (i_adv && !w_gated) begin
            r_err_prev     <= w_err;
            r_err_prev2    <= r_err_prev;
            r_integral_sum <= w_i_term;
            if (w_incr) begin
                r_last_drive <= w_res;
            end
        end
    end

    a_gated_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_gated) |=> (r_err_prev == $past(r_err_prev)) &&
                               (r_integral_sum == $past(r_integral_sum)) &&
                               (r_last_drive == $past(r_last_drive)))
        else $error("gated item changed controller state");

    a_history_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !w_gated) |=> (r_err_prev2 == $past(r_err_prev)))
        else $error("error history did not shift");

    a_position_keeps_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !w_incr) |=> $stable(r_last_drive))
        else $error("position form changed last drive");

endmodule

// ----- design/pid_position_incremental.sv -----
// PID controller in position or incremental form. Each transfer on the input channel
// carries a measured sample and a target; the block forms error = target - measured and
// returns one result transfer with the clamped drive, or drive 0 with gated set when the
// error is above max_error or below dead_band (either check off when 0), in which case no
// state changes. An item passes through the input register and then the result register;
// a new item is taken every cycle while the receiver does not stall the result register,
// since the single compute stage between the two registers also updates the error
// history, integral and last drive at the same edge that loads the result. Gains are signed
// Q8.8. Configuration registers are written through the config channel; the user must
// write them only while idle, since the block itself does not enforce it.
module pid_position_incremental
    import pip_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    pip_cfg_if.sink  i_cfg,
    pip_in_if.sink   i_in,
    pip_out_if.source o_out
);

    t_cfg               w_cfg;
    logic               w_adv;
    logic signed [31:0] w_drive;
    logic               w_gated;

    logic               r_in_valid;
    logic        [15:0] r_measured;
    logic        [15:0] r_target;
    logic               r_out_valid;
    logic        [31:0] r_drive;
    logic               r_gated;

    pip_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    pip_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_adv      (w_adv),
        .i_measured (r_measured),
        .i_target   (r_target),
        .o_drive    (w_drive),
        .o_gated    (w_gated)
    );

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    assign o_out.valid = r_out_valid;
    assign o_out.drive = r_drive;
    assign o_out.gated = r_gated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_measured <= i_in.measured;
            r_target   <= i_in.target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_drive <= w_drive;
            r_gated <= w_gated;
        end
    end

    a_gated_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_gated) |-> (r_drive == '0))
        else $error("gated result with nonzero drive");

    a_drive_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed({r_drive[31], r_drive}) <= $signed({2'b00, w_cfg.output_limit}))
                     && ($signed({r_drive[31], r_drive}) >= -$signed({2'b00, w_cfg.output_limit})))
        else $error("drive outside output limit");

    a_stage_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("held item did not reach result register");

endmodule

// ----- tb/tb_pid_position_incremental.sv -----
module tb_pid_position_incremental;
    import pip_pkg::*;

    typedef struct packed {
        logic [31:0] drive;
        logic        gated;
    } t_pid_result;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_cfg_idx    idx;
        logic [31:0] data;
        logic [15:0] meas;
        logic [15:0] tgt;
        bit          typed;
        t_pid_result want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    pip_in_if  in_if();
    pip_out_if out_if();
    pip_cfg_if cfg_if();

    pid_position_incremental dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // controller copy: settings
    t_mode  ctl_mode;
    longint kp, ki, kd;
    longint integ_cap, drive_cap, err_ceiling, err_floor;
    // controller copy: history
    longint prior_err, prior_err2, integ_acc, held_drive;

    t_pid_result due_outputs[$];
    t_pid_result head;
    t_stim_row   directed_rows[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          pressure_armed;
    logic        hold_off;
    logic [15:0] corners[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint sat_word(input longint x);
        if (x > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (x < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint clamp_sym(input longint x, input longint lim);
        if (x > lim) begin
            return lim;
        end else if (x < -lim) begin
            return -lim;
        end
        return x;
    endfunction

    function automatic t_pid_result run_controller(input logic [15:0] m, input logic [15:0] t);
        longint      e, mag, p, i_term, d, sum;
        t_pid_result r;
        e = longint'($signed(t)) - longint'($signed(m));
        mag = (e < 0) ? -e : e;
        r.drive = '0;
        r.gated = 1'b1;
        if ((err_ceiling != 0 && mag > err_ceiling) || (err_floor != 0 && mag < err_floor)) begin
            return r;
        end
        if (ctl_mode == MODE_POSITION) begin
            p = (kp * e) >>> GAIN_FRAC_BITS;
            i_term = clamp_sym(sat_word(integ_acc + ((ki * e) >>> GAIN_FRAC_BITS)), integ_cap);
            d = (kd * (e - prior_err)) >>> GAIN_FRAC_BITS;
            sum = clamp_sym(sat_word(p + i_term + d), drive_cap);
        end else begin
            p = (kp * (e - prior_err)) >>> GAIN_FRAC_BITS;
            i_term = clamp_sym(sat_word((ki * e) >>> GAIN_FRAC_BITS), integ_cap);
            d = (kd * (e - 2 * prior_err + prior_err2)) >>> GAIN_FRAC_BITS;
            sum = clamp_sym(sat_word(held_drive + sat_word(p + i_term + d)), drive_cap);
            held_drive = sum;
        end
        integ_acc = i_term;
        prior_err2 = prior_err;
        prior_err = e;
        r.drive = 32'(sum);
        r.gated = 1'b0;
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input t_pid_result want);
        if (mismatches < 10) begin
            $display("%s: drive exp %0d got %0d, gated exp %0b got %0b", what,
                     $signed(want.drive), $signed(out_if.drive), want.gated, out_if.gated);
        end
        mismatches++;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (due_outputs.size() == 0) begin
                note_mismatch("result with nothing due", '0);
            end else begin
                head = due_outputs.pop_front();
                if (out_if.drive !== head.drive || out_if.gated !== head.gated) begin
                    note_mismatch("result mismatch", head);
                end
            end
        end
        out_if.ready <= i_rst_n && !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        hold_off = 1'b0;
        wait (pressure_armed);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #8_000_000;
        $display("FAIL pid_position_incremental");
        $finish;
    end

    task automatic wait_quiet();
        while (due_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        case (idx)
            REG_MODE:           ctl_mode = t_mode'(d[0]);
            REG_GAIN_PROP:      kp = longint'($signed(d[15:0]));
            REG_GAIN_INTEG:     ki = longint'($signed(d[15:0]));
            REG_GAIN_DERIV:     kd = longint'($signed(d[15:0]));
            REG_INTEGRAL_LIMIT: integ_cap = longint'(d[30:0]);
            REG_OUTPUT_LIMIT:   drive_cap = longint'(d[30:0]);
            REG_MAX_ERROR:      err_ceiling = longint'(d[15:0]);
            REG_DEAD_BAND:      err_floor = longint'(d[15:0]);
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic [15:0] m, input logic [15:0] t, input bit typed,
                               input t_pid_result want);
        int          gap;
        t_pid_result predicted;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.measured <= m;
        in_if.target   <= t;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        predicted = run_controller(m, t);
        due_outputs.push_back(typed ? want : predicted);
    endtask

    task automatic tab_write(input t_cfg_idx idx, input logic [31:0] d);
        directed_rows.push_back('{ROW_WRITE, idx, d, 16'h0, 16'h0, 1'b0, '0});
    endtask

    task automatic tab_sample(input logic [15:0] m, input logic [15:0] t);
        directed_rows.push_back('{ROW_SAMPLE, REG_MODE, 32'h0, m, t, 1'b0, '0});
    endtask

    task automatic tab_known(input logic [15:0] m, input logic [15:0] t, input logic [31:0] drv,
                             input logic g);
        t_pid_result w;
        w.drive = drv;
        w.gated = g;
        directed_rows.push_back('{ROW_SAMPLE, REG_MODE, 32'h0, m, t, 1'b1, w});
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(3))
            0: return 16'($urandom_range(0, 2048) - 1024);
            1: return 16'($urandom);
            2: return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom_range(0, 512));
        endcase
    endfunction

    function automatic logic [30:0] pick_limit();
        case ($urandom_range(4))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom_range(1, 100000));
            3: return 31'($urandom_range(1, 5000000));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic apply_settings(input int seg);
        t_mode       m;
        logic [15:0] gp, gi, gd, band_hi, band_lo;
        logic [30:0] ilim, olim;
        if (seg < 4) begin
            // saturating corners in both forms
            m = t_mode'(seg[1]);
            gp = seg[0] ? 16'h8000 : 16'h7FFF;
            gi = gp;
            gd = seg[0] ? 16'h7FFF : 16'h8000;
            ilim = 31'h7FFF_FFFF;
            olim = 31'h7FFF_FFFF;
            band_hi = 16'h0;
            band_lo = 16'h0;
        end else begin
            m = t_mode'($urandom_range(1));
            gp = pick_gain();
            gi = pick_gain();
            gd = pick_gain();
            ilim = pick_limit();
            olim = pick_limit();
            band_hi = 16'h0;
            band_lo = 16'h0;
            if ($urandom_range(1) != 0) begin
                band_hi = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3000));
            end
            if ($urandom_range(1) != 0) begin
                band_lo = (band_hi != 0) ? 16'($urandom_range(1, band_hi))
                                         : 16'($urandom_range(1, 500));
            end
        end
        wait_quiet();
        write_reg(REG_MODE, {31'($urandom), m});
        write_reg(REG_GAIN_PROP, {16'($urandom), gp});
        write_reg(REG_GAIN_INTEG, {16'($urandom), gi});
        write_reg(REG_GAIN_DERIV, {16'($urandom), gd});
        write_reg(REG_INTEGRAL_LIMIT, {1'($urandom), ilim});
        write_reg(REG_OUTPUT_LIMIT, {1'($urandom), olim});
        write_reg(REG_MAX_ERROR, {16'($urandom), band_hi});
        write_reg(REG_DEAD_BAND, {16'($urandom), band_lo});
        cfg_if.valid <= 1'b0;
    endtask

    task automatic pick_sample(output logic [15:0] m, output logic [15:0] t);
        int base, span, v;
        case ($urandom_range(9))
            0, 1: begin
                m = 16'($urandom);
                t = 16'($urandom);
            end
            2: begin
                m = corners[$urandom_range(3)];
                t = corners[$urandom_range(3)];
            end
            default: begin
                // errors spread around the allowed band
                base = int'($urandom_range(0, 4000)) - 2000;
                span = (err_ceiling != 0) ? int'(err_ceiling) + 2 : 3000;
                v = base + int'($urandom_range(0, 2 * span)) - span;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                m = 16'(base);
                t = 16'(v);
            end
        endcase
    endtask

    initial begin
        bit          in_busy;
        bit          cfg_busy;
        logic [15:0] m, t;
        ctl_mode = MODE_POSITION;
        kp = 0;
        ki = 0;
        kd = 0;
        integ_cap = 0;
        drive_cap = 0;
        err_ceiling = 0;
        err_floor = 0;
        prior_err = 0;
        prior_err2 = 0;
        integ_acc = 0;
        held_drive = 0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pressure_armed = 1'b0;
        in_busy = 1'b0;
        cfg_busy = 1'b0;

        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.measured  <= 16'h0;
        in_if.target    <= 16'h0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= REG_MODE;
        cfg_if.data     <= 32'h0;

        // outputs stay zero while both limits are still at reset
        tab_known(16'h8000, 16'h7FFF, 32'h0, 1'b0);
        tab_known(16'h7FFF, 16'h8000, 32'h0, 1'b0);
        tab_write(REG_OUTPUT_LIMIT, 32'h7FFF_FFFF);
        tab_write(REG_INTEGRAL_LIMIT, 32'h7FFF_FFFF);
        tab_write(REG_GAIN_PROP, 32'h0000_7FFF);
        tab_write(REG_GAIN_INTEG, 32'h0000_8000);
        tab_write(REG_GAIN_DERIV, 32'h0000_7FFF);
        tab_write(REG_MODE, 32'(MODE_POSITION));
        tab_sample(16'h8000, 16'h7FFF);
        tab_sample(16'h7FFF, 16'h8000);
        tab_sample(16'h0000, 16'h0000);
        tab_sample(16'h5555, 16'hAAAA);
        tab_sample(16'hFFFF, 16'h0001);
        // error band edges
        tab_write(REG_MAX_ERROR, 32'd100);
        tab_write(REG_DEAD_BAND, 32'd10);
        tab_known(16'd0, 16'd101, 32'h0, 1'b1);
        tab_known(16'd101, 16'd0, 32'h0, 1'b1);
        tab_known(16'd0, 16'd9, 32'h0, 1'b1);
        tab_known(16'd9, 16'd0, 32'h0, 1'b1);
        tab_sample(16'd0, 16'd10);
        tab_sample(16'd0, 16'd100);
        tab_sample(16'd100, 16'd0);
        tab_write(REG_MODE, 32'(MODE_INCREMENTAL));
        tab_write(REG_MAX_ERROR, 32'd0);
        tab_write(REG_DEAD_BAND, 32'd0);
        tab_write(REG_GAIN_PROP, 32'h0000_8000);
        tab_write(REG_GAIN_INTEG, 32'h0000_7FFF);
        tab_write(REG_GAIN_DERIV, 32'h0000_8000);
        tab_sample(16'h8000, 16'h7FFF);
        tab_sample(16'h7FFF, 16'h8000);
        tab_sample(16'h7FFF, 16'h8000);
        tab_sample(16'h8000, 16'h7FFF);
        tab_write(REG_OUTPUT_LIMIT, 32'd0);
        tab_known(16'd100, 16'hFF38, 32'h0, 1'b0);
        tab_write(REG_INTEGRAL_LIMIT, 32'd0);
        tab_write(REG_OUTPUT_LIMIT, 32'd1000);
        tab_write(REG_MAX_ERROR, 32'h0000_FFFF);
        tab_write(REG_DEAD_BAND, 32'h0000_FFFF);
        tab_sample(16'h8000, 16'h7FFF);
        tab_known(16'd0, 16'd1, 32'h0, 1'b1);
        tab_known(16'd5, 16'd5, 32'h0, 1'b1);
        tab_write(REG_MODE, 32'(MODE_POSITION));
        tab_sample(16'h7FFF, 16'h8000);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_WRITE) begin
                if (in_busy) begin
                    in_if.valid <= 1'b0;
                    in_busy = 1'b0;
                    wait_quiet();
                end
                write_reg(directed_rows[k].idx, directed_rows[k].data);
                cfg_busy = 1'b1;
            end else begin
                if (cfg_busy) begin
                    cfg_if.valid <= 1'b0;
                    cfg_busy = 1'b0;
                end
                send_sample(directed_rows[k].meas, directed_rows[k].tgt,
                            directed_rows[k].typed, directed_rows[k].want);
                in_busy = 1'b1;
            end
        end
        in_if.valid <= 1'b0;

        for (int seg = 0; seg < 24; seg++) begin
            case (seg % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 85;
                end
                default: begin
                    send_idle_pct = 16;
                    recv_stall_pct = 16;
                end
            endcase
            apply_settings(seg);
            repeat (75) begin
                pick_sample(m, t);
                send_sample(m, t, 1'b0, '0);
            end
            in_if.valid <= 1'b0;
        end

        // back-pressure: sender keeps offering while the receiver holds off
        apply_settings(24);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pressure_armed = 1'b1;
        repeat (60) begin
            pick_sample(m, t);
            send_sample(m, t, 1'b0, '0);
        end
        in_if.valid <= 1'b0;

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && due_outputs.size() == 0) begin
            $display("PASS pid_position_incremental");
        end else begin
            $display("FAIL pid_position_incremental");
        end
        $finish;
    end

endmodule

// ----- pid_position_incremental.f -----
design/pip_pkg.sv
design/pip_if.sv
design/pip_cfg.sv
design/pip_core.sv
design/pid_position_incremental.sv
tb/tb_pid_position_incremental.sv
